FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the quantizer rtl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MSPQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define MSPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/mspq_pkg.sv
// ----------------------------------------------------------------------------
// mspq_pkg
// Types, constants and scale tables of the pitch quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mspq_pkg;

	localparam int PITCH_W = 16;
	localparam int NOTE_W  = 9;
	localparam int CORR_W  = 12;
	localparam int NW      = 13;   // internal note width
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam int SEMIS_PER_OCT = 12;

	// divide by three: (u * DIV3_MUL) >> DIV3_SHIFT, exact for u below 2**DIV3_SHIFT
	localparam int DIV3_W     = 12;
	localparam int PW         = 2 * DIV3_W;
	localparam int DIV3_MUL   = 2731;
	localparam int DIV3_SHIFT = 13;
	localparam int TQ_W       = 11;
	localparam int OCT_BIAS   = 512;
	localparam int U_BIAS     = 3 * OCT_BIAS;

	typedef enum logic [1:0] {
		LOCK_CHROMATIC = 2'd0,
		LOCK_SCALE     = 2'd1,
		LOCK_ROOT      = 2'd2
	} lock_mode_t;

	typedef enum logic [1:0] {
		REG_LOCK_MODE    = 2'd0,
		REG_ROOT_KEY     = 2'd1,
		REG_SCALE_SELECT = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		SCALE_MAJOR      = 4'd0,
		SCALE_MINOR      = 4'd1,
		SCALE_HARM_MINOR = 4'd2,
		SCALE_MEL_MINOR  = 4'd3,
		SCALE_DORIAN     = 4'd4,
		SCALE_PHRYGIAN   = 4'd5,
		SCALE_LYDIAN     = 4'd6,
		SCALE_MIXOLYDIAN = 4'd7,
		SCALE_LOCRIAN    = 4'd8,
		SCALE_MAJ_PENTA  = 4'd9,
		SCALE_MIN_PENTA  = 4'd10,
		SCALE_CHROMATIC  = 4'd11
	} scale_t;

	typedef struct packed {
		logic [1:0] lock_mode;
		logic [3:0] root_key;
		logic [3:0] scale_select;
	} cfg_t;

	// bit i set when the scale holds the interval of i semitones
	function automatic logic [11:0] scale_mask(input logic [3:0] sel);
		logic [11:0] mask;
		unique case (sel)
			SCALE_MAJOR:      mask = 12'hAB5;
			SCALE_MINOR:      mask = 12'h5AD;
			SCALE_HARM_MINOR: mask = 12'h9AD;
			SCALE_MEL_MINOR:  mask = 12'hAAD;
			SCALE_DORIAN:     mask = 12'h6AD;
			SCALE_PHRYGIAN:   mask = 12'h5AB;
			SCALE_LYDIAN:     mask = 12'hAD5;
			SCALE_MIXOLYDIAN: mask = 12'h6B5;
			SCALE_LOCRIAN:    mask = 12'h56B;
			SCALE_MAJ_PENTA:  mask = 12'h295;
			SCALE_MIN_PENTA:  mask = 12'h4A9;
			default:          mask = 12'hFFF;
		endcase
		return mask;
	endfunction

	// highest scale note at or below the semitone
	function automatic logic [3:0] scale_lo(input logic [11:0] mask, input logic [3:0] semi);
		logic [3:0] lo;
		int i;
		lo = '0;
		for (i = 0; i < SEMIS_PER_OCT; i++) begin
			if (mask[i] && (4'(i) <= semi)) begin
				lo = 4'(i);
			end
		end
		return lo;
	endfunction

	// lowest scale note above the semitone, the next octave root if none
	function automatic logic [3:0] scale_hi(input logic [11:0] mask, input logic [3:0] semi);
		logic [3:0] hi;
		int i;
		hi = 4'(SEMIS_PER_OCT);
		for (i = SEMIS_PER_OCT - 1; i >= 0; i--) begin
			if (mask[i] && (4'(i) > semi)) begin
				hi = 4'(i);
			end
		end
		return hi;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mspq_if.sv
// ----------------------------------------------------------------------------
// mspq_if
// Beat channels of the quantizer: pitch in, snapped note out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspq_pitch_if;
	logic                                valid;
	logic                                ready;
	logic signed [mspq_pkg::PITCH_W-1:0] pitch_in;

	modport source (output valid, output pitch_in, input ready);
	modport sink   (input valid, input pitch_in, output ready);
endinterface

interface mspq_note_if;
	logic                               valid;
	logic                               ready;
	logic signed [mspq_pkg::NOTE_W-1:0] snapped_note;
	logic signed [mspq_pkg::CORR_W-1:0] correction;

	modport source (output valid, output snapped_note, output correction, input ready);
	modport sink   (input valid, input snapped_note, input correction, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/musical_scale_pitch_quantizer_unit.sv
// depth: a pitch beat passes five register stages, s1 to s5, before its note beat is out
// throughput: one beat per cycle while the output is ready; full stages hold while it waits
// the five register stages and the divide-by-three reciprocal multiply set the depth
// reset: stage valids clear, config returns to scale lock, key C, natural minor
// ----------------------------------------------------------------------------
// musical_scale_pitch_quantizer_unit
// Snaps a fixed-point pitch to a chromatic, root or scale note grid and
// returns the note with the saturated correction toward it.
// ----------------------------------------------------------------------------
`default_nettype none

module musical_scale_pitch_quantizer_unit #(
	parameter int FRAC_BITS = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	mspq_pitch_if.sink                        pitch,
	mspq_note_if.source                       note,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [mspq_pkg::APB_AW-1:0]       paddr,
	input  wire  [mspq_pkg::APB_DW-1:0]       pwdata,
	output logic [mspq_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	mspq_pkg::cfg_t cfg;

	logic                                 mid_valid;
	logic                                 mid_ready;
	logic signed [mspq_pkg::PITCH_W-1:0]  mid_x;
	logic signed [mspq_pkg::NW-1:0]       mid_note_chrom;
	logic [mspq_pkg::PW-1:0]              mid_p_root;
	logic [mspq_pkg::PW-1:0]              mid_p_sc;
	logic [mspq_pkg::DIV3_W-1:0]          mid_u;
	logic [FRAC_BITS+1:0]                 mid_low;
	logic                                 mid_rel_neg;

	mspq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mspq_reduce #(
		.FRAC_BITS (FRAC_BITS)
	) u_reduce (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (pitch.valid),
		.in_ready       (pitch.ready),
		.pitch_in       (pitch.pitch_in),
		.out_valid      (mid_valid),
		.out_ready      (mid_ready),
		.x_out          (mid_x),
		.note_chrom_out (mid_note_chrom),
		.p_root_out     (mid_p_root),
		.p_sc_out       (mid_p_sc),
		.u_out          (mid_u),
		.low_out        (mid_low),
		.rel_neg_out    (mid_rel_neg)
	);

	mspq_snap #(
		.FRAC_BITS (FRAC_BITS)
	) u_snap (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (mid_valid),
		.in_ready      (mid_ready),
		.x_in          (mid_x),
		.note_chrom_in (mid_note_chrom),
		.p_root_in     (mid_p_root),
		.p_sc_in       (mid_p_sc),
		.u_in          (mid_u),
		.low_in        (mid_low),
		.rel_neg_in    (mid_rel_neg),
		.out_valid     (note.valid),
		.out_ready     (note.ready),
		.snapped_note  (note.snapped_note),
		.correction    (note.correction)
	);

endmodule

`default_nettype wire

FILE: rtl/core/mspq_cfg_regs.sv
// ----------------------------------------------------------------------------
// mspq_cfg_regs
// APB register file holding lock mode, root key and scale select.
// ----------------------------------------------------------------------------
`default_nettype none

module mspq_cfg_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [mspq_pkg::APB_AW-1:0]      paddr,
	input  wire  [mspq_pkg::APB_DW-1:0]      pwdata,
	output logic [mspq_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	output mspq_pkg::cfg_t                   cfg
);

	logic [1:0]     reg_idx;
	logic           wr_en;
	mspq_pkg::cfg_t cfg_q;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_mode    <= mspq_pkg::LOCK_SCALE;
			cfg_q.root_key     <= '0;
			cfg_q.scale_select <= mspq_pkg::SCALE_MINOR;
		end else if (wr_en) begin
			unique case (reg_idx)
				mspq_pkg::REG_LOCK_MODE:    cfg_q.lock_mode    <= pwdata[1:0];
				mspq_pkg::REG_ROOT_KEY:     cfg_q.root_key     <= pwdata[3:0];
				mspq_pkg::REG_SCALE_SELECT: cfg_q.scale_select <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mspq_pkg::REG_LOCK_MODE:    prdata = mspq_pkg::APB_DW'(cfg_q.lock_mode);
			mspq_pkg::REG_ROOT_KEY:     prdata = mspq_pkg::APB_DW'(cfg_q.root_key);
			mspq_pkg::REG_SCALE_SELECT: prdata = mspq_pkg::APB_DW'(cfg_q.scale_select);
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/mspq_reduce.sv
// ----------------------------------------------------------------------------
// mspq_reduce
// Front stages: key offset, chromatic rounding and octave reduction products.
// ----------------------------------------------------------------------------
`default_nettype none

module mspq_reduce #(
	parameter int FRAC_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  mspq_pkg::cfg_t                       cfg,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire signed [mspq_pkg::PITCH_W-1:0]   pitch_in,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [mspq_pkg::PITCH_W-1:0]  x_out,
	output logic signed [mspq_pkg::NW-1:0]       note_chrom_out,
	output logic [mspq_pkg::PW-1:0]              p_root_out,
	output logic [mspq_pkg::PW-1:0]              p_sc_out,
	output logic [mspq_pkg::DIV3_W-1:0]          u_out,
	output logic [FRAC_BITS+1:0]                 low_out,
	output logic                                 rel_neg_out
);

	localparam int F  = FRAC_BITS;
	localparam int XW = mspq_pkg::PITCH_W + 1;
	localparam int RW = ((F + 4 > mspq_pkg::PITCH_W) ? F + 4 : mspq_pkg::PITCH_W) + 2;
	localparam int NW = mspq_pkg::NW;
	localparam int PW = mspq_pkg::PW;
	localparam int DW = mspq_pkg::DIV3_W;

	localparam logic [XW:0] HALF_ONE = (XW + 1)'(1) << (F - 1);
	localparam logic [RW:0] SIX_ONE  = (RW + 1)'(6) << F;

	logic en1, en2;

	// stage 1
	logic signed [XW-1:0] xs;
	logic [XW-1:0]        ax;
	logic [XW:0]          rsum;
	logic [NW-1:0]        mag;
	logic signed [NW-1:0] note_chrom;
	logic signed [RW-1:0] x_ext;
	logic [RW-1:0]        key_off;
	logic signed [RW-1:0] rel;

	logic                 v_s1;
	logic signed [mspq_pkg::PITCH_W-1:0] x_s1;
	logic signed [RW-1:0] rel_s1;
	logic signed [NW-1:0] note_chrom_s1;

	// stage 2
	logic [RW-1:0]        abs_rel;
	logic [RW:0]          v_root;
	logic [DW-1:0]        t_root;
	logic signed [RW-1:0] rel_sh;
	logic signed [RW-1:0] u_wide;
	logic [DW-1:0]        u_sc;
	logic [PW-1:0]        p_root;
	logic [PW-1:0]        p_sc;

	logic                 v_s2;
	logic signed [mspq_pkg::PITCH_W-1:0] x_s2;
	logic signed [NW-1:0] note_chrom_s2;
	logic [PW-1:0]        p_root_s2;
	logic [PW-1:0]        p_sc_s2;
	logic [DW-1:0]        u_s2;
	logic [F+1:0]         low_s2;
	logic                 rel_neg_s2;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// chromatic rounding, halves away from zero
	always_comb begin
		xs         = XW'(pitch_in);
		ax         = xs[XW-1] ? XW'(-xs) : XW'(xs);
		rsum       = {1'b0, ax} + HALF_ONE;
		mag        = NW'(rsum >> F);
		note_chrom = xs[XW-1] ? NW'(-mag) : mag;
		x_ext      = RW'(pitch_in);
		key_off    = RW'(cfg.root_key) << F;
		rel        = x_ext - $signed(key_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1          <= pitch_in;
			rel_s1        <= rel;
			note_chrom_s1 <= note_chrom;
		end
	end

	// root mode quotient and floor octave index, both divided by three
	always_comb begin
		abs_rel = rel_s1[RW-1] ? RW'(-rel_s1) : RW'(rel_s1);
		v_root  = {1'b0, abs_rel} + SIX_ONE;
		t_root  = DW'(v_root >> (F + 2));
		rel_sh  = rel_s1 >>> (F + 2);
		u_wide  = rel_sh + $signed(RW'(mspq_pkg::U_BIAS));
		u_sc    = u_wide[DW-1:0];
		p_root  = PW'(t_root) * PW'(mspq_pkg::DIV3_MUL);
		p_sc    = PW'(u_sc) * PW'(mspq_pkg::DIV3_MUL);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2          <= x_s1;
			note_chrom_s2 <= note_chrom_s1;
			p_root_s2     <= p_root;
			p_sc_s2       <= p_sc;
			u_s2          <= u_sc;
			low_s2        <= rel_s1[F+1:0];
			rel_neg_s2    <= rel_s1[RW-1];
		end
	end

	assign out_valid      = v_s2;
	assign x_out          = x_s2;
	assign note_chrom_out = note_chrom_s2;
	assign p_root_out     = p_root_s2;
	assign p_sc_out       = p_sc_s2;
	assign u_out          = u_s2;
	assign low_out        = low_s2;
	assign rel_neg_out    = rel_neg_s2;

endmodule

`default_nettype wire

FILE: rtl/core/mspq_snap.sv
// ----------------------------------------------------------------------------
// mspq_snap
// Back stages: scale note pick, mode select and saturated correction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mspq_snap #(
	parameter int FRAC_BITS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  mspq_pkg::cfg_t                       cfg,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire signed [mspq_pkg::PITCH_W-1:0]   x_in,
	input  wire signed [mspq_pkg::NW-1:0]        note_chrom_in,
	input  wire [mspq_pkg::PW-1:0]               p_root_in,
	input  wire [mspq_pkg::PW-1:0]               p_sc_in,
	input  wire [mspq_pkg::DIV3_W-1:0]           u_in,
	input  wire [FRAC_BITS+1:0]                  low_in,
	input  wire                                  rel_neg_in,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [mspq_pkg::NOTE_W-1:0]   snapped_note,
	output logic signed [mspq_pkg::CORR_W-1:0]   correction
);

	localparam int F  = FRAC_BITS;
	localparam int NW = mspq_pkg::NW;
	localparam int DW = mspq_pkg::DIV3_W;
	localparam int QW = mspq_pkg::TQ_W;
	localparam int CW = ((NW + F > mspq_pkg::PITCH_W) ? NW + F : mspq_pkg::PITCH_W) + 1;

	localparam logic signed [CW-1:0] SAT_ONE   = CW'(6) <<< F;
	localparam logic signed [CW-1:0] HALF_ONE  = CW'(1) <<< (F - 1);
	localparam logic signed [CW-1:0] SCALE_GAP = CW'(3) <<< (F - 1);

	logic en3, en4, en5;

	// stage 3
	logic [QW-1:0]        q_root;
	logic [QW-1:0]        q_sc;
	logic [DW-1:0]        rem_full;
	logic [3:0]           semi;
	logic [11:0]          mask;
	logic [3:0]           lo;
	logic [3:0]           hi;
	logic signed [NW-1:0] key_n;
	logic signed [NW-1:0] base_n;
	logic signed [NW-1:0] oct_note;
	logic signed [NW-1:0] qr_n;
	logic signed [NW-1:0] qr12;
	logic signed [NW-1:0] note_root;

	logic                 v_s3;
	logic signed [mspq_pkg::PITCH_W-1:0] x_s3;
	logic signed [NW-1:0] note_chrom_s3;
	logic signed [NW-1:0] note_root_s3;
	logic signed [NW-1:0] oct_note_s3;
	logic [3:0]           lo_s3;
	logic [3:0]           hi_s3;
	logic [3:0]           semi_s3;
	logic [F-1:0]         frac_s3;

	// stage 4
	logic [F+3:0]         pos;
	logic [F+3:0]         dist_lo;
	logic [F+3:0]         dist_hi;
	logic [3:0]           pick;
	logic signed [NW-1:0] note_scale;
	logic signed [NW-1:0] note_sel;

	logic                 v_s4;
	logic signed [mspq_pkg::PITCH_W-1:0] x_s4;
	logic signed [NW-1:0] note_s4;

	// stage 5
	logic signed [CW-1:0] note_w;
	logic signed [CW-1:0] corr_full;
	logic signed [CW-1:0] corr_sat;

	logic                 v_s5;
	logic signed [mspq_pkg::NOTE_W-1:0] note_s5;
	logic signed [mspq_pkg::CORR_W-1:0] corr_s5;

	// assertion terms
	logic                 is_chrom;
	logic                 is_root;
	logic                 is_scale;
	logic                 near_half;
	logic                 near_gap;
	logic                 near_sat;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= in_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// octave of the key that holds the pitch, and position inside it
	always_comb begin
		q_root    = p_root_in[mspq_pkg::DIV3_SHIFT +: QW];
		q_sc      = p_sc_in[mspq_pkg::DIV3_SHIFT +: QW];
		rem_full  = u_in - DW'({q_sc, 1'b0}) - DW'(q_sc);
		semi      = {rem_full[1:0], low_in[F+1:F]};
		mask      = mspq_pkg::scale_mask(cfg.scale_select);
		lo        = mspq_pkg::scale_lo(mask, semi);
		hi        = mspq_pkg::scale_hi(mask, semi);
		key_n     = NW'(cfg.root_key);
		base_n    = $signed(NW'(q_sc)) - $signed(NW'(mspq_pkg::OCT_BIAS));
		oct_note  = key_n + (base_n <<< 3) + (base_n <<< 2);
		qr_n      = NW'(q_root);
		qr12      = (qr_n <<< 3) + (qr_n <<< 2);
		note_root = rel_neg_in ? key_n - qr12 : key_n + qr12;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			x_s3          <= x_in;
			note_chrom_s3 <= note_chrom_in;
			note_root_s3  <= note_root;
			oct_note_s3   <= oct_note;
			lo_s3         <= lo;
			hi_s3         <= hi;
			semi_s3       <= semi;
			frac_s3       <= low_in[F-1:0];
		end
	end

	// nearer of the two neighbors, tie to the lower one, then the lock mode picks the note
	always_comb begin
		pos        = {semi_s3, frac_s3};
		dist_lo    = pos - {lo_s3, {F{1'b0}}};
		dist_hi    = {hi_s3, {F{1'b0}}} - pos;
		pick       = (dist_hi < dist_lo) ? hi_s3 : lo_s3;
		note_scale = oct_note_s3 + $signed(NW'(pick));
		unique case (cfg.lock_mode)
			mspq_pkg::LOCK_CHROMATIC: note_sel = note_chrom_s3;
			mspq_pkg::LOCK_ROOT:      note_sel = note_root_s3;
			default:                  note_sel = note_scale;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			x_s4    <= x_s3;
			note_s4 <= note_sel;
		end
	end

	always_comb begin
		note_w    = CW'(note_s4);
		corr_full = (note_w <<< F) - CW'(x_s4);
		if (corr_full > SAT_ONE) begin
			corr_sat = SAT_ONE;
		end else if (corr_full < -SAT_ONE) begin
			corr_sat = -SAT_ONE;
		end else begin
			corr_sat = corr_full;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			note_s5 <= note_s4[mspq_pkg::NOTE_W-1:0];
			corr_s5 <= corr_sat[mspq_pkg::CORR_W-1:0];
		end
	end

	assign out_valid    = v_s5;
	assign snapped_note = note_s5;
	assign correction   = corr_s5;

	assign is_chrom  = v_s4 && (cfg.lock_mode == mspq_pkg::LOCK_CHROMATIC);
	assign is_root   = v_s4 && (cfg.lock_mode == mspq_pkg::LOCK_ROOT);
	assign is_scale  = v_s4 && !is_chrom && !is_root;
	assign near_half = (corr_full <= HALF_ONE) && (corr_full >= -HALF_ONE);
	assign near_gap  = (corr_full <= SCALE_GAP) && (corr_full >= -SCALE_GAP);
	assign near_sat  = (corr_full <= SAT_ONE) && (corr_full >= -SAT_ONE);

	`MSPQ_ASSERT_IMPL(a_div3_rem, clk, arst_n, v_s3 || in_valid, !in_valid || (rem_full < DW'(3)))
	`MSPQ_ASSERT_IMPL(a_chrom_near, clk, arst_n, is_chrom, near_half)
	`MSPQ_ASSERT_IMPL(a_scale_near, clk, arst_n, is_scale, near_gap)
	`MSPQ_ASSERT_IMPL(a_root_near, clk, arst_n, is_root, near_sat)
	`MSPQ_ASSERT_NEXT(a_s4_advance, clk, arst_n, v_s4 && en4, v_s5)

endmodule

`default_nettype wire
